// File: rtl/core/even_smooth_fft_size_assert.svh
// Assertion macros shared by the smooth FFT length search.
`ifndef EVEN_SMOOTH_FFT_SIZE_ASSERT_SVH
`define EVEN_SMOOTH_FFT_SIZE_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define ESFS_ASSERT_SAME(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// The condition must hold in the cycle after the trigger.
`define ESFS_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// File: rtl/core/esfs_pkg.sv
// Package with the shared constants and types of the smooth FFT length search.
package esfs_pkg;

	localparam int unsigned LENGTH_BITS_DEF = 20;

	typedef enum logic [1:0] {
		FACTOR_2,
		FACTOR_3,
		FACTOR_5,
		FACTOR_7
	} factor_t;

endpackage

// File: rtl/core/even_smooth_fft_size.sv
// Top level of the search for the smallest even 2-3-5-7 smooth FFT length.
//
// The block takes a requested transform length on the input channel (in_valid,
// in_ready, requested_length) and returns one good length on the output
// channel (out_valid, out_ready, good_length) for every transfer.
// The result is the smallest even number of the form 2^a*3^b*5^c*7^d that is at
// least the request; a request of zero gives zero and a request of one gives two.
// A sequencer walks the nested enumeration of products of 2, 3, 5 and 7 below
// the best bound found so far, one product per cycle through a single shared
// multiply-by-constant unit and its comparator against the bound.
// An item steps through each enumerated product, each pass of the innermost
// loop and of the loops on 5 and on 3, and then writes the result.
// The block is busy until the result is written and in_ready stays low.
// The result sits in an output register, so the next request is taken
// while a finished result still waits for out_ready; a stalled receiver only
// holds the block when a second result is finished before the first is taken.
// Reset clears the sequencer, the output valid flag and the output register; nothing else is kept
// between requests.
`include "even_smooth_fft_size_assert.svh"

module even_smooth_fft_size #(
	parameter int unsigned LENGTH_BITS = esfs_pkg::LENGTH_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [LENGTH_BITS:0]   requested_length,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [LENGTH_BITS+1:0] good_length
);

	localparam int unsigned IN_W = LENGTH_BITS + 1;
	localparam int unsigned W    = LENGTH_BITS + 2;
	localparam int unsigned PW   = W + 3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_L7,
		ST_L5,
		ST_L3,
		ST_L2,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic [W-1:0] good_length_q;

	logic [IN_W-1:0] n_q;
	logic [W-1:0]    bound_q;
	logic [W-1:0]    p2_q;
	logic [W-1:0]    p3_q;
	logic [W-1:0]    p5_q;
	logic [PW-1:0]   p7_q;

	esfs_pkg::factor_t factor;
	logic [W-1:0]  op;
	logic [PW-1:0] op_ext;
	logic [PW-1:0] prod;
	logic [PW-1:0] bound_ext;
	logic          prod_lt;
	logic          p7_lt;
	logic          p7_ge_n;
	logic          accept;
	logic          out_free;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign good_length = good_length_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		unique case (state_q)
			ST_L7: begin
				factor = esfs_pkg::FACTOR_7;
				op     = p7_q[W-1:0];
			end
			ST_L5: begin
				factor = esfs_pkg::FACTOR_5;
				op     = p5_q;
			end
			ST_L3: begin
				factor = esfs_pkg::FACTOR_3;
				op     = p3_q;
			end
			default: begin
				factor = esfs_pkg::FACTOR_2;
				op     = p2_q;
			end
		endcase
	end

	always_comb begin
		op_ext = {3'b000, op};
		unique case (factor)
			esfs_pkg::FACTOR_2: prod = op_ext << 1;
			esfs_pkg::FACTOR_3: prod = (op_ext << 1) + op_ext;
			esfs_pkg::FACTOR_5: prod = (op_ext << 2) + op_ext;
			esfs_pkg::FACTOR_7: prod = (op_ext << 3) - op_ext;
			default:            prod = op_ext;
		endcase
	end

	assign bound_ext = {3'b000, bound_q};
	assign prod_lt   = (prod < bound_ext);
	assign p7_lt     = (p7_q < bound_ext);
	assign p7_ge_n   = (p7_q >= {{(PW-IN_W){1'b0}}, n_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			out_valid_q   <= 1'b0;
			good_length_q <= '0;
		end else begin
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_L7;
					end
				end
				ST_L7: begin
					if (!p7_lt) begin
						state_q <= ST_L5;
					end
				end
				ST_L5: begin
					state_q <= prod_lt ? ST_L7 : ST_L3;
				end
				ST_L3: begin
					state_q <= prod_lt ? ST_L7 : ST_L2;
				end
				ST_L2: begin
					state_q <= prod_lt ? ST_L7 : ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						good_length_q <= bound_q;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					n_q     <= requested_length;
					bound_q <= {requested_length, 1'b0};
					p2_q    <= W'(2);
					p3_q    <= W'(2);
					p5_q    <= W'(2);
					p7_q    <= PW'(2);
				end
			end
			ST_L7: begin
				if (p7_lt) begin
					if (p7_ge_n) begin
						bound_q <= p7_q[W-1:0];
					end
					p7_q <= prod;
				end
			end
			ST_L5: begin
				if (prod_lt) begin
					p5_q <= prod[W-1:0];
					p7_q <= prod;
				end
			end
			ST_L3: begin
				if (prod_lt) begin
					p3_q <= prod[W-1:0];
					p5_q <= prod[W-1:0];
					p7_q <= prod;
				end
			end
			ST_L2: begin
				if (prod_lt) begin
					p2_q <= prod[W-1:0];
					p3_q <= prod[W-1:0];
					p5_q <= prod[W-1:0];
					p7_q <= prod;
				end
			end
			default: begin
			end
		endcase
	end

	`ESFS_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready, "block still ready after a transfer")
	`ESFS_ASSERT_NEXT(a_bound_shrinks, state_q != ST_IDLE, bound_q <= $past(bound_q), "bound grew")
	`ESFS_ASSERT_SAME(a_bound_covers_n, state_q != ST_IDLE, bound_q >= W'(n_q), "bound below request")
	`ESFS_ASSERT_SAME(a_loop_order, state_q == ST_L7, (p7_q >= PW'(p5_q)) && (p5_q >= p3_q) && (p3_q >= p2_q), "loop values out of order")
	`ESFS_ASSERT_SAME(a_result_even, out_valid_q, !good_length_q[0], "odd result")

endmodule

// File: verif/even_smooth_fft_size_test.sv
// Testbench for the even 2-3-5-7 smooth FFT length search with a scoreboard and random handshakes.
`timescale 1ns / 1ps

module even_smooth_fft_size_test;

	localparam int unsigned LB = esfs_pkg::LENGTH_BITS_DEF;
	localparam int unsigned RANDOM_REQUESTS = 560;
	localparam int unsigned STALL_LIMIT = 20000;
	localparam int unsigned HOLD_CYCLES = 3000;
	localparam int unsigned DRAIN_CYCLES = 1100;
	localparam int unsigned CORNER_COUNT = 23;
	localparam int unsigned CORNER_LENGTHS [CORNER_COUNT] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9,
		11, 13, 17, 97, 1000, 1023, 1025, 65537, 1048575, 1048576, 1048577, 2000000, 2097151};

	class length_scoreboard;
		logic [LB+1:0] expected_lengths[$];
		int unsigned mismatches;

		function logic [LB+1:0] smooth_length(logic [LB:0] n);
			longint unsigned lim, f2, f3, f5, f7;
			lim = 2 * longint'(n);
			for (f2 = 2; f2 < lim; f2 *= 2)
				for (f3 = f2; f3 < lim; f3 *= 3)
					for (f5 = f3; f5 < lim; f5 *= 5)
						for (f7 = f5; f7 < lim; f7 *= 7)
							if (f7 >= n)
								lim = f7;
			return lim[LB+1:0];
		endfunction

		function void note_request(logic [LB:0] n);
			expected_lengths = {expected_lengths, smooth_length(n)};
		endfunction

		function void check_length(logic [LB+1:0] actual);
			logic [LB+1:0] want;
			if (expected_lengths.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected good_length %0d", actual);
				return;
			end
			want = expected_lengths.pop_front();
			if (actual !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: good_length expected %0d, got %0d", want, actual);
			end
		endfunction

		function int unsigned pending();
			return expected_lengths.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [LB:0] requested_length;
	logic out_valid;
	logic out_ready;
	logic [LB+1:0] good_length;

	length_scoreboard sb = new();
	int unsigned results_seen;
	int unsigned quiet_cycles;

	even_smooth_fft_size dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.requested_length(requested_length),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.good_length(good_length)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic send_request(input logic [LB:0] n);
		in_valid <= 1'b1;
		requested_length <= n;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_request(n);
	endtask

	task automatic sender_gap(input int unsigned cycles);
		in_valid <= 1'b0;
		requested_length <= (LB+1)'($urandom);
		repeat (cycles)
			@(posedge clk);
	endtask

	function automatic logic [LB:0] random_request();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return (LB+1)'($urandom_range(0, 1023));
		else if (pick < 80)
			return (LB+1)'($urandom_range(0, 65535));
		else if (pick < 92)
			return (LB+1)'($urandom_range(0, 1048576));
		else
			return (LB+1)'($urandom);
	endfunction

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		requested_length <= '0;
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int c = 0; c < CORNER_COUNT; c++) begin
			send_request((LB+1)'(CORNER_LENGTHS[c]));
			if ($urandom_range(0, 99) < 10)
				sender_gap($urandom_range(1, 5));
		end
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			if (i == 250) begin
				in_valid <= 1'b0;
				while (sb.pending() != 0)
					@(posedge clk);
			end
			send_request(random_request());
			if ((i < 350 || i > 450) && $urandom_range(0, 99) < 10)
				sender_gap($urandom_range(1, 5));
		end
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		bit held;
		held = 1'b0;
		results_seen = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				sb.check_length(good_length);
				results_seen++;
			end
			if (!held && results_seen == 120) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(posedge clk);
			end else if (results_seen >= 300 && results_seen <= 400)
				out_ready <= 1'b1;
			else
				out_ready <= ($urandom_range(0, 99) >= 10);
		end
	end

	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end
	end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/esfs_pkg.sv
rtl/core/even_smooth_fft_size.sv
verif/even_smooth_fft_size_test.sv
